[rtl/bsrc_pkg.sv]
package bsrc_pkg;

  // Default sizes of the block.
  localparam int MAX_PROCESSES_DEF = 16;
  localparam int MAX_RESOURCES_DEF = 8;
  localparam int COUNT_WIDTH_DEF   = 8;

  // Input item modes.
  localparam logic [2:0] MODE_ALLOC   = 3'd0;
  localparam logic [2:0] MODE_CLAIM   = 3'd1;
  localparam logic [2:0] MODE_AVAIL   = 3'd2;
  localparam logic [2:0] MODE_REQUEST = 3'd3;
  localparam logic [2:0] MODE_CHECK   = 3'd4;

  // Verdict codes.
  localparam logic [1:0] VERDICT_SAFE      = 2'd0;
  localparam logic [1:0] VERDICT_UNSAFE    = 2'd1;
  localparam logic [1:0] VERDICT_CLAIM     = 2'd2;
  localparam logic [1:0] VERDICT_NOT_AVAIL = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_PROCESS_COUNT  = 2'd0;
  localparam logic [1:0] REG_RESOURCE_COUNT = 2'd1;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_REQ,
    S_CLM_RD,
    S_CLM_CHK,
    S_AV_CHK,
    S_GR_RD,
    S_GR_WR,
    S_SF_INIT,
    S_SF_ROW,
    S_SF_RD,
    S_SF_CMP,
    S_SF_ADD_RD,
    S_SF_ADD,
    S_RB_RD,
    S_RB_WR,
    S_SINGLE,
    S_EM_RD,
    S_EM_OUT
  } state_t;

endpackage

[rtl/bankers_safety_and_request_check.sv]
// Banker's algorithm engine. Each item either loads one table entry (allocation, maximum claim
// or available units), stores one request element, or starts an evaluation: a safety check
// (mode 4) or, on the last request element, a claim check, an availability check, a tentative
// grant and a safety check. All evaluation runs on one shared compare/add datapath behind a
// single read port on each table memory, stepped by a small sequencer; in_ready is low until
// it finishes. The claim check, availability check, grant and rollback each step through the
// resource types in use one at a time. With P processes in use, a safety check visits at most
// P passes of P rows; a finished row is skipped, an unfinished one is read and compared per
// resource up to the first misfit, and a fitting row's allocation is read and added to the
// work vector; the check stops early once all processes are finished or a pass makes no
// progress. A safe outcome is sent as P items; any other outcome is a single item. Results
// sit in an output register, so the next item is taken while the last result still waits.
module bankers_safety_and_request_check
  #(
    parameter int MAX_PROCESSES = bsrc_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = bsrc_pkg::MAX_RESOURCES_DEF,
    parameter int COUNT_WIDTH   = bsrc_pkg::COUNT_WIDTH_DEF
  )
  (
    input  logic       clk,
    input  logic       rst,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [4:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] mode,
    input  logic [3:0] process_index,
    input  logic [2:0] resource_index,
    input  logic [7:0] amount,
    input  logic       request_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] verdict,
    output logic [3:0] order_process,
    output logic       order_valid,
    output logic       last_result
  );
  import bsrc_pkg::*;

  localparam int PW   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int RW   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int PCW  = $clog2(MAX_PROCESSES + 1);
  localparam int RCW  = $clog2(MAX_RESOURCES + 1);
  localparam int CW   = COUNT_WIDTH;
  localparam int WW   = COUNT_WIDTH + PCW;
  localparam int AW   = PW + RW;
  localparam int DEPTH = 1 << AW;

  state_t state, state_next;

  logic [PCW-1:0] pc;
  logic [RCW-1:0] rc;

  // Table memories and their registered read data.
  logic [CW-1:0] alloc_mem [DEPTH];
  logic [CW-1:0] claim_mem [DEPTH];
  logic [CW-1:0] alloc_q;
  logic [CW-1:0] claim_q;
  logic [PW-1:0] order_mem [MAX_PROCESSES];
  logic [PW-1:0] order_q;

  logic [CW-1:0] avail   [MAX_RESOURCES];
  logic [CW-1:0] req_vec [MAX_RESOURCES];
  logic [WW-1:0] work    [MAX_RESOURCES];
  logic [MAX_PROCESSES-1:0] finished;

  logic [PCW-1:0] scan_p;
  logic [PCW-1:0] count;
  logic [PCW-1:0] k;
  logic [RW-1:0]  r_idx;
  logic [PW-1:0]  req_p;
  logic           progress;
  logic           is_req;
  logic [1:0]     single_verdict;

  logic [AW-1:0]  mem_addr;
  logic           alloc_we;
  logic           claim_we;
  logic [CW-1:0]  alloc_wdata;

  logic [15:0]    pin_ext;
  logic [15:0]    rin_ext;
  logic [15:0]    amt_ext;
  logic [CW-1:0]  amt_cw;
  logic           p_ok;
  logic           r_ok;
  logic           accept;
  logic [CW:0]    need;
  logic           need_neg;
  logic           r_last;
  logic           p_end;
  logic           all_done;
  logic           k_last;
  logic           load_out;
  logic [PW-1:0]  row;
  logic [31:0]    cfg_v;

  // Input decoding.
  assign pin_ext = 16'(process_index);
  assign rin_ext = 16'(resource_index);
  assign amt_ext = 16'(amount);
  assign amt_cw  = amt_ext[CW-1:0];
  assign p_ok    = pin_ext < 16'(MAX_PROCESSES);
  assign r_ok    = rin_ext < 16'(MAX_RESOURCES);
  assign accept  = in_valid && in_ready;

  // Shared compare datapath.
  assign need     = {1'b0, claim_q} - {1'b0, alloc_q};
  assign need_neg = need[CW];
  assign r_last   = (RCW'(r_idx) == rc - RCW'(1));
  assign p_end    = (scan_p == pc);
  assign all_done = (count == pc);
  assign k_last   = (k == pc - PCW'(1));
  assign row      = (state == S_SF_RD || state == S_SF_ADD_RD) ? scan_p[PW-1:0] : req_p;
  assign cfg_v    = 32'(cfg_data);

  // Memory port control.
  always_comb begin
    mem_addr    = {row, r_idx};
    alloc_we    = 1'b0;
    claim_we    = 1'b0;
    alloc_wdata = alloc_q + req_vec[r_idx];
    case (state)
      S_IDLE: begin
        mem_addr    = {pin_ext[PW-1:0], rin_ext[RW-1:0]};
        alloc_wdata = amt_cw;
        alloc_we    = accept && (mode == MODE_ALLOC) && p_ok && r_ok;
        claim_we    = accept && (mode == MODE_CLAIM) && p_ok && r_ok;
      end
      S_GR_WR: alloc_we = 1'b1;
      S_RB_WR: begin
        alloc_we    = 1'b1;
        alloc_wdata = alloc_q - req_vec[r_idx];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (alloc_we) begin
      alloc_mem[mem_addr] <= alloc_wdata;
    end
    if (claim_we) begin
      claim_mem[mem_addr] <= amt_cw;
    end
    alloc_q <= alloc_mem[mem_addr];
    claim_q <= claim_mem[mem_addr];
  end

  // Safe order memory.
  always_ff @(posedge clk) begin
    if (state == S_SF_ADD && r_last) begin
      order_mem[count[PW-1:0]] <= scan_p[PW-1:0];
    end
    order_q <= order_mem[k[PW-1:0]];
  end

  // Sequencer: next state and handshake.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid) begin
          if (mode == MODE_REQUEST && request_last) begin
            state_next = S_REQ;
          end else if (mode == MODE_CHECK) begin
            state_next = S_SF_INIT;
          end
        end
      end
      S_REQ: begin
        if (16'(req_p) >= 16'(pc)) begin
          state_next = S_SINGLE;
        end else begin
          state_next = S_CLM_RD;
        end
      end
      S_CLM_RD:  state_next = S_CLM_CHK;
      S_CLM_CHK: begin
        if (need_neg || req_vec[r_idx] > need[CW-1:0]) begin
          state_next = S_SINGLE;
        end else if (r_last) begin
          state_next = S_AV_CHK;
        end else begin
          state_next = S_CLM_RD;
        end
      end
      S_AV_CHK: begin
        if (req_vec[r_idx] > avail[r_idx]) begin
          state_next = S_SINGLE;
        end else if (r_last) begin
          state_next = S_GR_RD;
        end
      end
      S_GR_RD: state_next = S_GR_WR;
      S_GR_WR: begin
        if (r_last) begin
          state_next = S_SF_INIT;
        end else begin
          state_next = S_GR_RD;
        end
      end
      S_SF_INIT: state_next = S_SF_ROW;
      S_SF_ROW: begin
        if (all_done) begin
          state_next = S_EM_RD;
        end else if (p_end && !progress) begin
          state_next = is_req ? S_RB_RD : S_SINGLE;
        end else if (!p_end && !finished[scan_p[PW-1:0]]) begin
          state_next = S_SF_RD;
        end
      end
      S_SF_RD: state_next = S_SF_CMP;
      S_SF_CMP: begin
        if (!need_neg && WW'(need[CW-1:0]) > work[r_idx]) begin
          state_next = S_SF_ROW;
        end else if (r_last) begin
          state_next = S_SF_ADD_RD;
        end else begin
          state_next = S_SF_RD;
        end
      end
      S_SF_ADD_RD: state_next = S_SF_ADD;
      S_SF_ADD: begin
        if (r_last) begin
          state_next = S_SF_ROW;
        end else begin
          state_next = S_SF_ADD_RD;
        end
      end
      S_RB_RD: state_next = S_RB_WR;
      S_RB_WR: begin
        if (r_last) begin
          state_next = S_SINGLE;
        end else begin
          state_next = S_RB_RD;
        end
      end
      S_SINGLE: begin
        if (!out_valid) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EM_RD: state_next = S_EM_OUT;
      S_EM_OUT: begin
        if (!out_valid) begin
          load_out   = 1'b1;
          state_next = k_last ? S_IDLE : S_EM_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers: state, configuration and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= PCW'(1);
      rc        <= RCW'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write && cfg_index == REG_PROCESS_COUNT) begin
        if (cfg_v == 32'd0) begin
          pc <= PCW'(1);
        end else if (cfg_v > 32'(MAX_PROCESSES)) begin
          pc <= PCW'(MAX_PROCESSES);
        end else begin
          pc <= cfg_v[PCW-1:0];
        end
      end
      if (cfg_write && cfg_index == REG_RESOURCE_COUNT) begin
        if (cfg_v[3:0] == 4'd0) begin
          rc <= RCW'(1);
        end else if (32'(cfg_v[3:0]) > 32'(MAX_RESOURCES)) begin
          rc <= RCW'(MAX_RESOURCES);
        end else begin
          rc <= cfg_v[RCW-1:0];
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers stepped by the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        r_idx <= '0;
        if (accept && mode == MODE_AVAIL && r_ok) begin
          avail[rin_ext[RW-1:0]] <= amt_cw;
        end
        if (accept && mode == MODE_REQUEST && r_ok) begin
          req_vec[rin_ext[RW-1:0]] <= amt_cw;
        end
        if (accept) begin
          req_p  <= pin_ext[PW-1:0];
          is_req <= (mode == MODE_REQUEST);
        end
      end
      S_REQ: begin
        single_verdict <= VERDICT_CLAIM;
        r_idx          <= '0;
      end
      S_CLM_CHK: begin
        r_idx <= r_last ? '0 : r_idx + RW'(1);
      end
      S_AV_CHK: begin
        single_verdict <= VERDICT_NOT_AVAIL;
        r_idx          <= r_last ? '0 : r_idx + RW'(1);
      end
      S_GR_WR: begin
        avail[r_idx] <= avail[r_idx] - req_vec[r_idx];
        r_idx        <= r_last ? '0 : r_idx + RW'(1);
      end
      S_SF_INIT: begin
        for (int i = 0; i < MAX_RESOURCES; i++) begin
          work[i] <= (32'(i) < 32'(rc)) ? WW'(avail[i]) : '0;
        end
        finished       <= '0;
        count          <= '0;
        scan_p         <= '0;
        progress       <= 1'b0;
        r_idx          <= '0;
        k              <= '0;
        single_verdict <= VERDICT_UNSAFE;
      end
      S_SF_ROW: begin
        r_idx <= '0;
        if (p_end) begin
          scan_p   <= '0;
          progress <= 1'b0;
        end else if (finished[scan_p[PW-1:0]]) begin
          scan_p <= scan_p + PCW'(1);
        end
      end
      S_SF_CMP: begin
        if (!need_neg && WW'(need[CW-1:0]) > work[r_idx]) begin
          scan_p <= scan_p + PCW'(1);
          r_idx  <= '0;
        end else begin
          r_idx <= r_last ? '0 : r_idx + RW'(1);
        end
      end
      S_SF_ADD: begin
        work[r_idx] <= work[r_idx] + WW'(alloc_q);
        r_idx       <= r_last ? '0 : r_idx + RW'(1);
        if (r_last) begin
          finished[scan_p[PW-1:0]] <= 1'b1;
          count                    <= count + PCW'(1);
          progress                 <= 1'b1;
          scan_p                   <= scan_p + PCW'(1);
        end
      end
      S_RB_WR: begin
        avail[r_idx] <= avail[r_idx] + req_vec[r_idx];
        r_idx        <= r_last ? '0 : r_idx + RW'(1);
      end
      S_EM_OUT: begin
        if (!out_valid) begin
          k <= k + PCW'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state == S_EM_OUT) begin
        verdict       <= VERDICT_SAFE;
        order_process <= 4'(order_q);
        order_valid   <= 1'b1;
        last_result   <= k_last;
      end else begin
        verdict       <= single_verdict;
        order_process <= 4'd0;
        order_valid   <= 1'b0;
        last_result   <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // A run entry always carries a safe verdict.
  a_order_safe: assert property (@(posedge clk) disable iff (rst)
    out_valid && order_valid |-> verdict == VERDICT_SAFE)
    else $error("order entry with non-safe verdict");

  // A single verdict is always the end of its run.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !order_valid |-> last_result)
    else $error("single verdict not marked last");

  // The finish count never passes the number of processes in use.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SF_ROW |-> count <= pc)
    else $error("finish count beyond process count");

  // No item is taken while an evaluation is under way.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready)
    else $error("item accepted while busy");
`endif

endmodule
